// ----- rtl/skc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted keyed sighting counter package
// Sizes, the entry type and the control group that is broadcast to the cells.
// ----------------------------------------------------------------------------
package skc_pkg;

  localparam int CAPACITY   = 32;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int FILL_BITS  = $clog2(CAPACITY + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Sighting opcodes.
  localparam logic OP_SIGHT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } skc_entry_t;

  // Control broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic                sight;   // a sighting beat is being taken this cycle
    logic                insert;  // the sighted key is new and there is room
    logic                rotate;  // report: every entry moves one place headwards
    logic [KEY_BITS-1:0] key;     // key of the sighting beat
  } skc_ctrl_t;

endpackage

// ----- rtl/skc_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted keyed sighting counter cell
// Holds one table entry; compares it with the broadcast key and takes its
// neighbour's entry when a new key is inserted or the table is rotated.
// ----------------------------------------------------------------------------
module skc_cell
  import skc_pkg::*;
(
  input  logic       clk,
  input  skc_ctrl_t  ctrl,
  input  logic       occ,         // this cell lies below the fill count
  input  logic       is_tail,     // this cell holds the last occupied entry
  input  logic       left_less,   // headward neighbour holds a key below the broadcast key
  input  skc_entry_t left_data,
  input  skc_entry_t right_data,
  input  skc_entry_t head_data,
  output skc_entry_t data,
  output logic       less,
  output logic       eq
);

  skc_entry_t data_r;

  assign data = data_r;
  assign less = occ && (data_r.key < ctrl.key);
  assign eq   = occ && (data_r.key == ctrl.key);

  // The insert point is the first cell whose key is not below the new key;
  // every cell behind it takes its headward neighbour's entry.
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      data_r <= is_tail ? head_data : right_data;
    end else if (ctrl.insert) begin
      if (!less && left_less) begin
        data_r.key   <= ctrl.key;
        data_r.count <= '0;
      end else if (!less) begin
        data_r <= left_data;
      end
    end else if (ctrl.sight && eq && (data_r.count != COUNT_MAX)) begin
      data_r.count <= data_r.count + 1'b1;
    end
  end

endmodule

// ----- rtl/sorted_keyed_sighting_counter.sv -----
// ----------------------------------------------------------------------------
// Sorted keyed sighting counter
// Keeps a sorted table of distinct keys with saturating counts in a chain of
// cells, and reports the whole table after each batch.
// ----------------------------------------------------------------------------
// Report: a sighting that closes a batch is followed by a report of
// fill_count beats (1 to CAPACITY), one per cycle; the first is registered
// from the head cell once the block has entered its report state.
// Throughput: one beat per cycle, except that start is refused (busy high)
// while a report streams out, as the report rotates the table through the
// cell chain once. The receiver cannot stall the report.
// Reset: synchronous, active low; empties the table and clears the overflow flag.
// ----------------------------------------------------------------------------
module sorted_keyed_sighting_counter
  import skc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic                  in_end_of_batch,
  output logic                  out_strobe,
  output logic [KEY_BITS-1:0]   out_entry_key,
  output logic [COUNT_BITS-1:0] out_entry_count,
  output logic                  out_last_entry,
  output logic                  out_overflowed
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  logic                 state_r, state_nxt;
  logic [FILL_BITS-1:0] fill_r, fill_nxt;
  logic [FILL_BITS-1:0] idx_r, idx_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 accept, sight, clear, full, any_eq, insert, rpt_last;
  skc_ctrl_t            ctrl;

  skc_entry_t           cell_data [CAPACITY];
  logic [CAPACITY-1:0]  less_vec;
  logic [CAPACITY-1:0]  eq_vec;

  logic                  out_strobe_r;
  logic [KEY_BITS-1:0]   out_key_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  // A beat is taken whenever start is high and no report is running.
  assign busy   = (state_r == ST_REPORT);
  assign accept = start && !busy;
  assign sight  = accept && (in_opcode == OP_SIGHT);
  assign clear  = accept && (in_opcode == OP_CLEAR);

  // Because the keys are unique, at most one cell can match. A new key goes
  // in only when nothing matched and a free cell remains; if nothing matched
  // but the table is full, it is dropped and the sticky overflow flag records the loss.
  assign full   = (fill_r == FILL_BITS'(CAPACITY));
  assign any_eq = |eq_vec;
  assign insert = sight && !any_eq && !full;

  assign ctrl.sight  = sight;
  assign ctrl.insert = insert;
  assign ctrl.rotate = busy;
  assign ctrl.key    = in_key;

  // The report walks the table by rotating the occupied cells towards the
  // head once: the head entry leaves on each cycle and re-enters at the tail,
  // so once every entry has been reported the table stands as it was.
  assign rpt_last = (FILL_BITS'(idx_r + 1'b1) == fill_r);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic       left_less;
      skc_entry_t left_data;
      skc_entry_t right_data;

      if (gi == 0) begin : g_head
        assign left_less = 1'b1;
        assign left_data = cell_data[0];
      end else begin : g_body
        assign left_less = less_vec[gi-1];
        assign left_data = cell_data[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_end
        assign right_data = cell_data[0];
      end else begin : g_mid
        assign right_data = cell_data[gi+1];
      end

      skc_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (FILL_BITS'(gi) < fill_r),
        .is_tail    (fill_r == FILL_BITS'(gi + 1)),
        .left_less  (left_less),
        .left_data  (left_data),
        .right_data (right_data),
        .head_data  (cell_data[0]),
        .data       (cell_data[gi]),
        .less       (less_vec[gi]),
        .eq         (eq_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (clear) begin
          fill_nxt = '0;
        end else if (sight) begin
          if (insert) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (!any_eq && full) begin
            ovf_nxt = 1'b1;
          end
          if (in_end_of_batch) begin
            state_nxt = ST_REPORT;
            idx_nxt   = '0;
          end
        end
      end
      ST_REPORT: begin
        idx_nxt = idx_r + 1'b1;
        if (rpt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      idx_r        <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      idx_r        <= idx_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= busy;
    end
  end

  // Result beat registers: loaded from the head cell while the report runs.
  always_ff @(posedge clk) begin
    if (busy) begin
      out_key_r   <= cell_data[0].key;
      out_count_r <= cell_data[0].count;
      out_last_r  <= rpt_last;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_count = out_count_r;
  assign out_last_entry  = out_last_r;
  assign out_overflowed  = out_ovf_r;

endmodule

// ----- rtl/skc_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted keyed sighting counter checker
// Port-level properties of the report stream, bound to the top level.
// ----------------------------------------------------------------------------
module skc_checker
  import skc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_opcode,
  input logic                  in_end_of_batch,
  input logic                  out_strobe,
  input logic [KEY_BITS-1:0]   out_entry_key,
  input logic                  out_last_entry,
  input logic                  out_overflowed
);

  // A sighting that closes a batch always starts a report.
  a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_opcode == OP_SIGHT) && in_end_of_batch |=> busy)
    else $error("report did not start after end of batch");

  // The block leaves the report just as the final beat is shown.
  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe && out_last_entry)
    else $error("report ended without a last beat");

  // Beats of one report follow back to back.
  a_report_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_entry |=> out_strobe)
    else $error("gap inside a report");

  // Keys come out strictly ascending within a report.
  a_report_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_entry |=> out_entry_key > $past(out_entry_key))
    else $error("report keys not ascending");

  // The overflow flag is the same on every beat of a report.
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_entry |=> $stable(out_overflowed))
    else $error("overflow flag changed inside a report");

endmodule

bind sorted_keyed_sighting_counter skc_checker u_skc_checker (.*);
